// ----- hdl/lzrd_pkg.sv -----
// Shared types and constants for the LZSS ring decompressor.
// No dependencies; imported by lzrd_ring and lzss_ring_decompressor_unit.
package lzrd_pkg;

    // Default history ring depth in bytes
    localparam int RING_SIZE_DEF = 4096;
    // Ring position of the first byte written after a stream start
    localparam int START_POINTER = 'hfee;
    // Tokens described by one flag byte
    localparam int FLAGS_PER_BYTE = 8;
    // Shortest match, added to the length nibble
    localparam int MATCH_MIN = 3;

    // Token parser phase
    typedef enum logic [1:0] {
        PH_FLAG   = 2'd0,
        PH_TOKEN  = 2'd1,
        PH_SECOND = 2'd2
    } phase_t;

    // Sequencer state
    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_M_READ = 2'd1,
        ST_M_EMIT = 2'd2
    } state_t;

    // Control strobes from the sequencer to the ring
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic clear;
    } ring_ctrl_t;

endpackage

// ----- hdl/lzrd_ring.sv -----
// History ring memory with a fill count that makes unwritten entries read as zero.
// Depends on lzrd_pkg.
module lzrd_ring
    import lzrd_pkg::*;
#(
    parameter int RING_SIZE = RING_SIZE_DEF,
    localparam int PTR_W = $clog2(RING_SIZE)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ring_ctrl_t       ctrl,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [7:0]       wr_data,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [7:0]       rd_data
);

    localparam logic [PTR_W-1:0] START_PTR = PTR_W'(START_POINTER);

    logic [7:0]     mem [RING_SIZE];
    logic [PTR_W:0] fill_reg;
    logic [PTR_W:0] fill_next;
    logic [7:0]     rd_data_reg;
    logic           rd_hit_reg;
    logic [PTR_W-1:0] rd_offset;
    logic           rd_written;

    // Writes go out sequentially from START_PTR, so an entry holds data iff
    // its distance from the start is below the number of bytes written
    assign rd_offset  = rd_addr - START_PTR;
    assign rd_written = fill_reg[PTR_W] | ({1'b0, rd_offset} < fill_reg);

    // Fill count, saturating at the ring depth
    always_comb begin
        fill_next = fill_reg;
        if (ctrl.clear) begin
            fill_next = '0;
        end else if (ctrl.wr_en && !fill_reg[PTR_W]) begin
            fill_next = fill_reg + (PTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Memory write port
    always_ff @(posedge aclk) begin
        if (ctrl.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read
    always_ff @(posedge aclk) begin
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_hit_reg  <= rd_written;
        end
    end

    assign rd_data = rd_hit_reg ? rd_data_reg : 8'h00;

endmodule

// ----- hdl/lzss_ring_decompressor_unit.sv -----
// LZSS decompressor with a history ring, stream ports in and out.
// Literals, flag bytes and first match bytes are handled as they are accepted. The second
// match byte starts a copy of length 3 to 18 in which each byte takes a ring read, then
// an emit step that writes the byte back, emits it and steps the read and write pointers
// and the shared count adder; the copy also stops when the output length is reached.
// Each emit waits while the receiver holds off, and the block is not ready while a copy
// runs or while the output register holds a byte the receiver is not taking. The ring
// reads as zero after reset and after each stream start through a fill count, without a
// clearing pass. The length register is to be written only while the block is idle; the
// block itself does not enforce it.
// Depends on lzrd_pkg and lzrd_ring.
module lzss_ring_decompressor_unit
    import lzrd_pkg::*;
#(
    parameter int RING_SIZE = RING_SIZE_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: output_length
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    // compressed input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [0:0]  s_tuser,   // [0] stream_start
    // decompressed output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // last
);

    localparam int PTR_W = $clog2(RING_SIZE);
    localparam logic [PTR_W-1:0] START_PTR = PTR_W'(START_POINTER);

    state_t           state_reg, state_next;
    phase_t           phase_reg, phase_next;
    logic [7:0]       flag_bits_reg, flag_bits_next;
    logic [3:0]       flags_left_reg, flags_left_next;
    logic [7:0]       first_reg, first_next;
    logic [31:0]      produced_reg, produced_next;
    logic [31:0]      length_reg, length_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] pos_reg, pos_next;
    logic [4:0]       remaining_reg, remaining_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    ring_ctrl_t       ring_ctrl;
    logic [7:0]       ring_wr_data;
    logic [7:0]       ring_rd_data;

    logic             out_free;
    logic             accept;
    logic             start;
    logic [31:0]      prod_base;
    logic             stream_done;
    logic [31:0]      prod_inc;
    logic             last_hit;
    logic [3:0]       flags_left_dec;
    phase_t           phase_after;
    logic             out_load;

    lzrd_ring #(
        .RING_SIZE (RING_SIZE)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ring_ctrl),
        .wr_addr (wp_reg),
        .wr_data (ring_wr_data),
        .rd_addr (pos_reg),
        .rd_data (ring_rd_data)
    );

    // Handshake
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;
    assign start    = s_tuser[0];

    // Stream completion check, counting from zero on a stream start
    assign prod_base   = start ? 32'd0 : produced_reg;
    assign stream_done = prod_base >= length_reg;

    // Shared count unit: next produced count and its end compare
    assign prod_inc = produced_reg + 32'd1;
    assign last_hit = prod_inc >= length_reg;

    // Token bookkeeping after a literal or a match
    assign flags_left_dec = (flags_left_reg != 4'd0) ? flags_left_reg - 4'd1 : flags_left_reg;
    assign phase_after    = (flags_left_dec == 4'd0) ? PH_FLAG : PH_TOKEN;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        flag_bits_next  = flag_bits_reg;
        flags_left_next = flags_left_reg;
        first_next      = first_reg;
        produced_next   = produced_reg;
        wp_next         = wp_reg;
        pos_next        = pos_reg;
        remaining_next  = remaining_reg;
        ring_ctrl       = '0;
        ring_wr_data    = s_tdata;
        out_load        = 1'b0;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        length_next     = cfg_we ? cfg_wdata : length_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (start) begin
                        ring_ctrl.clear = 1'b1;
                        wp_next         = START_PTR;
                        flag_bits_next  = 8'h00;
                        flags_left_next = 4'd0;
                        phase_next      = PH_FLAG;
                        first_next      = 8'h00;
                        produced_next   = 32'd0;
                    end
                    if (!stream_done) begin
                        case (start ? PH_FLAG : phase_reg)
                            PH_TOKEN: begin
                                if (flag_bits_reg[7]) begin
                                    // literal
                                    out_load        = 1'b1;
                                    m_data_next     = s_tdata;
                                    m_last_next     = last_hit;
                                    ring_ctrl.wr_en = 1'b1;
                                    ring_wr_data    = s_tdata;
                                    wp_next         = wp_reg + PTR_W'(1);
                                    produced_next   = prod_inc;
                                    flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
                                    flags_left_next = flags_left_dec;
                                    phase_next      = phase_after;
                                end else begin
                                    first_next = s_tdata;
                                    phase_next = PH_SECOND;
                                end
                            end
                            PH_SECOND: begin
                                // second match byte: start the copy
                                remaining_next = {1'b0, first_reg[3:0]} + 5'(MATCH_MIN);
                                pos_next       = PTR_W'({s_tdata, first_reg[7:4]});
                                state_next     = ST_M_READ;
                            end
                            default: begin
                                flag_bits_next  = s_tdata;
                                flags_left_next = 4'(FLAGS_PER_BYTE);
                                phase_next      = PH_TOKEN;
                            end
                        endcase
                    end
                end
            end
            ST_M_READ: begin
                ring_ctrl.rd_en = 1'b1;
                state_next      = ST_M_EMIT;
            end
            ST_M_EMIT: begin
                if (out_free) begin
                    out_load        = 1'b1;
                    m_data_next     = ring_rd_data;
                    m_last_next     = last_hit;
                    ring_ctrl.wr_en = 1'b1;
                    ring_wr_data    = ring_rd_data;
                    wp_next         = wp_reg + PTR_W'(1);
                    pos_next        = pos_reg + PTR_W'(1);
                    produced_next   = prod_inc;
                    remaining_next  = remaining_reg - 5'd1;
                    if (last_hit || remaining_reg == 5'd1) begin
                        flag_bits_next  = {flag_bits_reg[6:0], 1'b0};
                        flags_left_next = flags_left_dec;
                        phase_next      = phase_after;
                        state_next      = ST_IDLE;
                    end else begin
                        state_next = ST_M_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_FLAG;
            flag_bits_reg  <= 8'h00;
            flags_left_reg <= 4'd0;
            first_reg      <= 8'h00;
            produced_reg   <= 32'd0;
            length_reg     <= 32'd0;
            wp_reg         <= START_PTR;
            remaining_reg  <= 5'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            flag_bits_reg  <= flag_bits_next;
            flags_left_reg <= flags_left_next;
            first_reg      <= first_next;
            produced_reg   <= produced_next;
            length_reg     <= length_next;
            wp_reg         <= wp_next;
            remaining_reg  <= remaining_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // A copy in progress always has bytes left
    a_emit_remaining: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_EMIT) |-> (remaining_reg != 5'd0))
        else $error("copy state with no bytes left");

    // Every ring write goes with an output byte
    a_write_with_output: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_ctrl.wr_en |-> out_load)
        else $error("ring written without an output transfer");

    // Output register is only loaded when free
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> out_free)
        else $error("output register overwritten");

    // A ring read is always followed by the emit step
    a_read_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_M_READ) |=> (state_reg == ST_M_EMIT))
        else $error("ring read not followed by emit");

endmodule
